[hw/rtl/nsl_pkg.sv]
// ----------------------------------------------------------------------------
// Next smooth length package
// Payload types, register indexes, reset values and the command and status
// bundles shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package nsl_pkg;

    localparam int REQ_W         = 32;
    localparam int OUT_W         = 31;
    localparam int FACTOR_W      = 8;
    localparam int COUNT_W       = 3;
    localparam int FACTOR_REGS   = 6;
    localparam int CFG_IDX_W     = 3;
    localparam int DIV_STEP_BITS = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR_FIRST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR_LAST  = 3'd6;

    typedef logic [FACTOR_W-1:0] t_factor;

    localparam logic [COUNT_W-1:0] FACTOR_COUNT_RESET = 3'd3;
    localparam t_factor FACTOR_RESET [FACTOR_REGS] = '{
        8'd2, 8'd3, 8'd5, 8'd7, 8'd11, 8'd13
    };

    typedef struct packed {
        logic signed [REQ_W-1:0] requested_length;
        logic                    length_missing;
    } t_req;

    typedef struct packed {
        logic [OUT_W-1:0] smooth_length;
        logic             result_missing;
        logic             overflow;
    } t_res;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [FACTOR_W-1:0]  data;
    } t_cfg;

    typedef struct packed {
        logic take;
        logic init;
        logic descend;
        logic lvl_dec;
        logic lvl_inc;
        logic mul;
        logic mul_apply;
        logic test_init;
        logic div_start;
        logic div_take;
        logic record;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic quick;
        logic leaf;
        logic at_root;
        logic better;
        logic reach;
        logic fac_ok;
        logic mul_over;
        logic div_done;
        logic rem_zero;
        logic v_one;
    } t_sts;

endpackage

[hw/rtl/nsl_if.sv]
// ----------------------------------------------------------------------------
// Next smooth length channels
// Valid/ready interfaces for the request, result and configuration channels.
// ----------------------------------------------------------------------------
interface nsl_req_if import nsl_pkg::*; ();
    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface nsl_res_if import nsl_pkg::*; ();
    logic valid;
    logic ready;
    t_res payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface nsl_cfg_if import nsl_pkg::*; ();
    logic valid;
    logic ready;
    t_cfg payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/nsl_div.sv]
// ----------------------------------------------------------------------------
// Next smooth length divisibility unit
// Restoring division of a value by an 8-bit factor, several bits per cycle.
// ----------------------------------------------------------------------------
module nsl_div import nsl_pkg::*; #(
    parameter int VALUE_BITS = 31
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [VALUE_BITS-1:0] i_dividend,
    input  t_factor               i_divisor,
    output logic                  o_done,
    output logic [VALUE_BITS-1:0] o_quotient,
    output logic                  o_rem_zero
);

    localparam int DW   = ((VALUE_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS) * DIV_STEP_BITS;
    localparam int NCYC = DW / DIV_STEP_BITS;
    localparam int CW   = $clog2(NCYC + 1);

    logic [DW-1:0]       r_q;
    logic [DW-1:0]       n_q;
    logic [FACTOR_W-1:0] r_rem;
    logic [FACTOR_W-1:0] n_rem;
    t_factor             r_divisor;
    logic [CW-1:0]       r_cnt;
    logic                r_busy;
    logic                r_done;

    // Each step shifts the top dividend bit into the partial remainder.
    always_comb begin
        logic [FACTOR_W:0] t;
        n_q   = r_q;
        n_rem = r_rem;
        for (int k = 0; k < DIV_STEP_BITS; k++) begin
            t   = {n_rem, n_q[DW-1]};
            n_q = {n_q[DW-2:0], 1'b0};
            if (t >= {1'b0, r_divisor}) begin
                t      = t - {1'b0, r_divisor};
                n_q[0] = 1'b1;
            end
            n_rem = t[FACTOR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(NCYC);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != CW'(1));
            r_done <= (r_cnt == CW'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q       <= DW'(i_dividend);
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q[VALUE_BITS-1:0];
    assign o_rem_zero = (r_rem == '0);

endmodule

[hw/rtl/nsl_dp.sv]
// ----------------------------------------------------------------------------
// Next smooth length datapath
// Product stack for the walk over factor powers, best answer so far, the
// level multiplier, the divisibility test and the result register.
// ----------------------------------------------------------------------------
module nsl_dp import nsl_pkg::*; #(
    parameter int MAX_FACTORS = 6,
    parameter int VALUE_BITS  = 31
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  t_req               i_req,
    input  logic [COUNT_W-1:0] i_factor_count,
    input  t_factor            i_factors [MAX_FACTORS],
    output t_res               o_res
);

    localparam int LW = $clog2(MAX_FACTORS + 1);
    localparam int MW = VALUE_BITS + FACTOR_W;

    logic signed [REQ_W-1:0] r_len;
    logic                    r_miss;
    logic [VALUE_BITS-1:0]   r_target;
    logic [VALUE_BITS-1:0]   r_best;
    logic                    r_found;
    logic [VALUE_BITS-1:0]   r_prod [MAX_FACTORS + 1];
    logic [LW-1:0]           r_lvl;
    logic [MW-1:0]           r_mul;
    logic [VALUE_BITS-1:0]   r_v;
    t_res                    r_res;
    t_res                    n_res;

    logic [LW-1:0]         levels;
    logic [LW-1:0]         lvl_up;
    t_factor               fac;
    logic [VALUE_BITS-1:0] p;
    logic                  is_small;
    logic                  is_over;
    logic                  div_done;
    logic                  div_rem_zero;
    logic [VALUE_BITS-1:0] div_quot;

    // A count above the number of factor slots uses all slots.
    assign levels = (i_factor_count > COUNT_W'(MAX_FACTORS)) ? LW'(MAX_FACTORS)
                                                              : LW'(i_factor_count);
    assign lvl_up = r_lvl + 1'b1;
    assign p      = r_prod[r_lvl];

    always_comb begin
        fac = '0;
        for (int i = 0; i < MAX_FACTORS; i++) begin
            if (r_lvl == LW'(i)) begin
                fac = i_factors[i];
            end
        end
    end

    assign is_small = r_len[REQ_W-1] || (r_len[OUT_W-1:0] <= OUT_W'(1));
    assign is_over  = ((r_len[OUT_W-1:0] >> VALUE_BITS) != '0);

    assign o_sts.quick    = r_miss || is_small || is_over;
    assign o_sts.leaf     = (r_lvl == levels);
    assign o_sts.at_root  = (r_lvl == '0);
    assign o_sts.better   = !r_found || (p < r_best);
    assign o_sts.reach    = (p >= r_target);
    // Factors of 0 or 1 are skipped as if not in use.
    assign o_sts.fac_ok   = (fac >= t_factor'(2));
    assign o_sts.mul_over = (r_mul[MW-1:VALUE_BITS] != '0);
    assign o_sts.div_done = div_done;
    assign o_sts.rem_zero = div_rem_zero;
    assign o_sts.v_one    = (r_v == VALUE_BITS'(1));

    nsl_div #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_v),
        .i_divisor  (fac),
        .o_done     (div_done),
        .o_quotient (div_quot),
        .o_rem_zero (div_rem_zero)
    );

    always_comb begin
        n_res = '0;
        if (r_miss) begin
            n_res.result_missing = 1'b1;
        end else if (is_small) begin
            n_res.smooth_length = OUT_W'(1);
        end else if (is_over || !r_found) begin
            n_res.overflow = 1'b1;
        end else begin
            n_res.smooth_length = OUT_W'(r_best);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl   <= '0;
            r_found <= 1'b0;
        end else begin
            if (i_cmd.init) begin
                r_lvl   <= '0;
                r_found <= 1'b0;
            end else if (i_cmd.descend || i_cmd.lvl_inc) begin
                r_lvl <= lvl_up;
            end else if (i_cmd.lvl_dec) begin
                r_lvl <= r_lvl - 1'b1;
            end else if (i_cmd.test_init) begin
                r_lvl <= '0;
            end
            if (i_cmd.record) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_len  <= i_req.requested_length;
            r_miss <= i_req.length_missing;
        end
        if (i_cmd.init) begin
            r_target  <= r_len[VALUE_BITS-1:0];
            r_prod[0] <= VALUE_BITS'(1);
        end
        if (i_cmd.descend) begin
            r_prod[lvl_up] <= p;
        end
        if (i_cmd.mul) begin
            r_mul <= MW'(p) * MW'(fac);
        end
        if (i_cmd.mul_apply) begin
            r_prod[r_lvl] <= r_mul[VALUE_BITS-1:0];
        end
        if (i_cmd.test_init) begin
            r_v <= p;
        end else if (i_cmd.div_take) begin
            r_v <= div_quot;
        end
        if (i_cmd.record) begin
            r_best <= p;
        end
        if (i_cmd.out_load) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

    a_lvl_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lvl <= levels)
        else $error("walk level beyond the number of factors in use");

    a_best_reaches_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> (r_best >= r_target))
        else $error("recorded answer below the requested length");

    a_record_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.record |-> (r_v == VALUE_BITS'(1)))
        else $error("answer recorded without a full factorization");

endmodule

[hw/rtl/nsl_ctrl.sv]
// ----------------------------------------------------------------------------
// Next smooth length controller
// Sequences the walk over factor products, the divisibility test of each
// candidate and the handshakes of the request and result channels.
// ----------------------------------------------------------------------------
module nsl_ctrl import nsl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_START = 10'b0000000010,
        S_CHECK = 10'b0000000100,
        S_UP    = 10'b0000001000,
        S_MUL   = 10'b0000010000,
        S_MCHK  = 10'b0000100000,
        S_TSEL  = 10'b0001000000,
        S_TWAIT = 10'b0010000000,
        S_TDONE = 10'b0100000000,
        S_FIN   = 10'b1000000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                if (i_sts.quick) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.init = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.leaf) begin
                    if (i_sts.reach && i_sts.better) begin
                        o_cmd.test_init = 1'b1;
                        n_state         = S_TSEL;
                    end else begin
                        n_state = S_UP;
                    end
                end else if (i_sts.better) begin
                    o_cmd.descend = 1'b1;
                end else begin
                    n_state = S_UP;
                end
            end
            S_UP: begin
                if (i_sts.at_root) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.lvl_dec = 1'b1;
                    n_state       = S_MUL;
                end
            end
            S_MUL: begin
                // A level without a usable factor holds one power only.
                if (!i_sts.fac_ok) begin
                    n_state = S_UP;
                end else begin
                    o_cmd.mul = 1'b1;
                    n_state   = S_MCHK;
                end
            end
            S_MCHK: begin
                if (i_sts.mul_over) begin
                    n_state = S_UP;
                end else begin
                    o_cmd.mul_apply = 1'b1;
                    n_state         = S_CHECK;
                end
            end
            S_TSEL: begin
                if (i_sts.leaf) begin
                    n_state = S_TDONE;
                end else if (!i_sts.fac_ok) begin
                    o_cmd.lvl_inc = 1'b1;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_TWAIT;
                end
            end
            S_TWAIT: begin
                if (i_sts.div_done) begin
                    if (i_sts.rem_zero) begin
                        o_cmd.div_take = 1'b1;
                    end else begin
                        o_cmd.lvl_inc = 1'b1;
                    end
                    n_state = S_TSEL;
                end
            end
            S_TDONE: begin
                if (i_sts.v_one) begin
                    o_cmd.record = 1'b1;
                end
                n_state = S_UP;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_take_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> (r_state == S_START))
        else $error("accepted request did not start processing");

    a_wait_division: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TWAIT && !i_sts.div_done) |=> (r_state == S_TWAIT))
        else $error("left the division wait before the unit finished");

    a_div_usable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> i_sts.fac_ok)
        else $error("division started with an unusable factor");

endmodule

[hw/rtl/next_smooth_length.sv]
// ----------------------------------------------------------------------------
// Next smooth length
// Rounds a requested length up to the smallest product of the factors in use
// that a greedy division by those factors, in order, reduces to one.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload                                    Accepted when
//  i_req     in         requested_length, length_missing           valid & ready
//  o_res     out        smooth_length, result_missing, overflow    valid & ready
//  i_cfg     in         index, data                                valid & ready
//
//  A missing, small or out-of-range request goes from S_START straight to S_FIN,
//  which loads its result. Otherwise the controller walks every product of the
//  factors in use below the best answer found so far: it descends a level in
//  S_CHECK and moves a level to its next power through S_UP, S_MUL and S_MCHK,
//  and tests each candidate by repeated divisions in S_TSEL and S_TWAIT. Reset
//  is synchronous and loads a factor count of three, so the default factors 2,
//  3, 5 are in use. The last state of an item, S_FIN, waits while an earlier
//  result is still held in the output register. A new request is taken while
//  a result waits in the output register.
// ----------------------------------------------------------------------------
module next_smooth_length import nsl_pkg::*; #(
    parameter int MAX_FACTORS = 6,
    parameter int VALUE_BITS  = 31
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    nsl_req_if.sink       i_req,
    nsl_res_if.source     o_res,
    nsl_cfg_if.sink       i_cfg
);

    logic [COUNT_W-1:0] r_factor_count;
    t_factor            r_factor [FACTOR_REGS];
    t_factor            dp_factors [MAX_FACTORS];
    t_cmd               cmd;
    t_sts               sts;

    assign i_cfg.ready = 1'b1;

    // Writes to indexes past the last factor register are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor_count <= FACTOR_COUNT_RESET;
            r_factor       <= FACTOR_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            if (i_cfg.payload.index == CFG_FACTOR_COUNT) begin
                r_factor_count <= i_cfg.payload.data[COUNT_W-1:0];
            end else if (i_cfg.payload.index >= CFG_FACTOR_FIRST &&
                         i_cfg.payload.index <= CFG_FACTOR_LAST) begin
                r_factor[i_cfg.payload.index - CFG_FACTOR_FIRST] <= i_cfg.payload.data;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_FACTORS; i++) begin
            dp_factors[i] = r_factor[i];
        end
    end

    nsl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    nsl_dp #(
        .MAX_FACTORS (MAX_FACTORS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_req          (i_req.payload),
        .i_factor_count (r_factor_count),
        .i_factors      (dp_factors),
        .o_res          (o_res.payload)
    );

endmodule

[bench/nsl_length_checker.sv]
// ----------------------------------------------------------------------------
// Next smooth length checker
// Watches the request, result and configuration channels, keeps its own copy
// of the factor registers, predicts every result at request acceptance and
// compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module nsl_length_checker import nsl_pkg::*; #(
    parameter int MAX_FACTORS = 6,
    parameter int VALUE_BITS  = 31
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    nsl_req_if    i_req,
    nsl_res_if    i_res,
    nsl_cfg_if    i_cfg,
    output int    o_errors,
    output int    o_pending
);

    localparam longint unsigned LENGTH_LIMIT = (64'd1 << VALUE_BITS) - 64'd1;

    logic [COUNT_W-1:0] cfg_count;
    t_factor            cfg_factor [FACTOR_REGS];
    t_res               expected_q [$];
    int                 errors = 0;

    // Greedy test: divide by each factor in order as often as it goes evenly.
    function automatic bit greedy_accepts(input longint unsigned value,
                                          input longint unsigned fac [FACTOR_REGS],
                                          input int n);
        longint unsigned v;
        v = value;
        for (int i = 0; i < n; i++) begin
            while (v % fac[i] == 0) begin
                v = v / fac[i];
                if (v == 1)
                    return 1'b1;
            end
        end
        return v == 1;
    endfunction

    function automatic t_res round_up_smooth(input logic [REQ_W-1:0] req,
                                             input logic miss);
        t_res            r;
        longint unsigned fac [FACTOR_REGS];
        longint unsigned cur [FACTOR_REGS+1];
        longint unsigned best;
        longint unsigned target;
        int              n;
        int              nf;
        int              lv;
        bit              dup;
        bit              climb;
        r = '0;
        if (miss) begin
            r.result_missing = 1'b1;
            return r;
        end
        if (req[REQ_W-1] || req <= 1) begin
            r.smooth_length = 1;
            return r;
        end
        if (longint'(req) > LENGTH_LIMIT) begin
            r.overflow = 1'b1;
            return r;
        end
        nf = (cfg_count > MAX_FACTORS) ? MAX_FACTORS : cfg_count;
        if (nf > FACTOR_REGS)
            nf = FACTOR_REGS;
        n = 0;
        for (int i = 0; i < nf; i++) begin
            if (cfg_factor[i] >= 2) begin
                dup = 1'b0;
                for (int j = 0; j < n; j++)
                    if (fac[j] == cfg_factor[i])
                        dup = 1'b1;
                if (!dup) begin
                    fac[n] = cfg_factor[i];
                    n++;
                end
            end
        end
        target = req;
        best = LENGTH_LIMIT + 1;
        // Depth-first walk over all products of the factors, pruned by the
        // best answer so far. Level lv holds the running power of factor lv;
        // climb is set when control returns from the level below.
        lv = 0;
        cur[0] = 1;
        climb = 1'b0;
        while (lv >= 0) begin
            if (lv == n) begin
                if (cur[n] >= target && cur[n] < best && greedy_accepts(cur[n], fac, n))
                    best = cur[n];
                lv--;
                climb = 1'b1;
            end else if (!climb) begin
                if (cur[lv] <= LENGTH_LIMIT && cur[lv] < best) begin
                    cur[lv+1] = cur[lv];
                    lv++;
                end else begin
                    lv--;
                    climb = 1'b1;
                end
            end else if (cur[lv] > LENGTH_LIMIT / fac[lv]) begin
                lv--;
            end else begin
                cur[lv] = cur[lv] * fac[lv];
                climb = 1'b0;
            end
        end
        if (best > LENGTH_LIMIT)
            r.overflow = 1'b1;
        else
            r.smooth_length = best[OUT_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (!i_rst_n) begin
            cfg_count = FACTOR_COUNT_RESET;
            for (int k = 0; k < FACTOR_REGS; k++)
                cfg_factor[k] = FACTOR_RESET[k];
            expected_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.payload.index == CFG_FACTOR_COUNT) begin
                    cfg_count = i_cfg.payload.data[COUNT_W-1:0];
                end else if (i_cfg.payload.index >= CFG_FACTOR_FIRST &&
                             i_cfg.payload.index <= CFG_FACTOR_LAST) begin
                    cfg_factor[i_cfg.payload.index - CFG_FACTOR_FIRST] = i_cfg.payload.data;
                end
            end
            if (i_req.valid && i_req.ready)
                expected_q.push_back(round_up_smooth(i_req.payload.requested_length,
                                                     i_req.payload.length_missing));
            if (i_res.valid && i_res.ready) begin
                got = i_res.payload;
                if (expected_q.size() == 0) begin
                    $error("result transaction with no request waiting: length %0d",
                           got.smooth_length);
                    errors++;
                end else begin
                    want = expected_q.pop_front();
                    if (got.smooth_length !== want.smooth_length) begin
                        $error("smooth_length: expected %0d, actual %0d",
                               want.smooth_length, got.smooth_length);
                        errors++;
                    end
                    if (got.result_missing !== want.result_missing) begin
                        $error("result_missing: expected %0b, actual %0b",
                               want.result_missing, got.result_missing);
                        errors++;
                    end
                    if (got.overflow !== want.overflow) begin
                        $error("overflow: expected %0b, actual %0b",
                               want.overflow, got.overflow);
                        errors++;
                    end
                end
            end
        end
        o_pending <= expected_q.size();
        o_errors <= errors;
    end

endmodule

[bench/tb_next_smooth_length.sv]
// ----------------------------------------------------------------------------
// Next smooth length testbench
// Drives directed and random length requests through several factor settings,
// with random idle bursts on the request and result channels, and reports
// the verdict from the failure and pending counts of the channel checker.
// ----------------------------------------------------------------------------
module tb_next_smooth_length;
    import nsl_pkg::*;

    localparam int MAX_FACTORS = 6;
    localparam int VALUE_BITS  = 31;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 110;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = CFG_FACTOR_LAST + 3'd1;

    logic clk;
    logic rst_n;
    bit   idling;
    int   check_errors;
    int   check_pending;

    nsl_req_if req_ch ();
    nsl_res_if res_ch ();
    nsl_cfg_if cfg_ch ();

    next_smooth_length #(
        .MAX_FACTORS (MAX_FACTORS),
        .VALUE_BITS  (VALUE_BITS)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    nsl_length_checker #(
        .MAX_FACTORS (MAX_FACTORS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_checker (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_req     (req_ch),
        .i_res     (res_ch),
        .i_cfg     (cfg_ch),
        .o_errors  (check_errors),
        .o_pending (check_pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #2_000_000_000;
        $display("tb_next_smooth_length: FAIL");
        $finish;
    end

    // Result side: ready drops in random bursts while idling is set.
    initial begin
        int hold;
        hold = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold > 0) begin
                hold--;
                res_ch.ready <= 1'b0;
            end else if (idling && $urandom_range(0, 4) == 0) begin
                hold = $urandom_range(0, 4);
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Valid stays high across back-to-back transactions; it is only lowered
    // for a gap or by settle_block.
    task automatic send_length(input logic [REQ_W-1:0] len, input logic miss);
        int gap;
        if (idling && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.payload <= '{len, miss};
        do @(posedge clk); while (!req_ch.ready);
    endtask

    task automatic put_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.payload <= '{idx, val};
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    task automatic settle_block();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (check_pending != 0);
        repeat (16) @(posedge clk);
    endtask

    // Upper bits of the count write are ignored by the block.
    task automatic write_config(input logic [COUNT_W-1:0] count,
                                input t_factor fac [FACTOR_REGS],
                                input bit stray);
        logic [7:0] count_data;
        settle_block();
        count_data = 8'($urandom_range(0, 255));
        count_data[COUNT_W-1:0] = count;
        put_register(CFG_FACTOR_COUNT, count_data);
        for (int k = 0; k < FACTOR_REGS; k++)
            put_register(CFG_FACTOR_FIRST + 3'(k), fac[k]);
        if (stray)
            put_register(CFG_UNMAPPED, 8'($urandom_range(0, 255)));
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic t_factor pick_factor();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 8'($urandom_range(0, 1));
        if (r < 3)
            return 8'($urandom_range(17, 255));
        return 8'($urandom_range(2, 16));
    endfunction

    // Mostly short lengths keep the search cheap; long ones are rare.
    function automatic logic [REQ_W-1:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return {1'b1, 31'($urandom())};
        if (r < 12)
            return 32'($urandom_range(0, 2));
        if (r < 57)
            return 32'($urandom_range(2, 300));
        if (r < 88)
            return 32'($urandom_range(2, 1 << $urandom_range(9, 16)));
        if (r < 99)
            return 32'($urandom_range(2, 1 << 24));
        return 32'($urandom_range(1 << 24, 32'h7FFF_FFFF));
    endfunction

    initial begin
        t_factor            fac [FACTOR_REGS];
        logic [COUNT_W-1:0] count;
        idling = 1'b0;
        rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.payload <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.payload <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Reset factors 2, 3 and 5: missing inputs, tiny and negative lengths,
        // a power of two and the top of the range, which has no answer.
        send_length(32'd12345, 1'b1);
        send_length(32'h8000_0000, 1'b1);
        send_length(32'd0, 1'b0);
        send_length(32'd1, 1'b0);
        send_length(32'hFFFF_FFFF, 1'b0);
        send_length(32'h8000_0000, 1'b0);
        send_length(32'd2, 1'b0);
        send_length(32'd7, 1'b0);
        send_length(32'h4000_0000, 1'b0);
        send_length(32'h7FFF_FFFF, 1'b0);
        send_length(32'd1000001, 1'b0);

        // No factor in use: everything above one overflows.
        fac = '{8'd2, 8'd3, 8'd5, 8'd7, 8'd11, 8'd13};
        write_config(3'd0, fac, 1'b0);
        send_length(32'd5, 1'b0);
        send_length(32'd1, 1'b0);

        // A count above the limit is clamped to all six factors.
        write_config(3'd7, fac, 1'b0);
        send_length(32'd17, 1'b0);
        send_length(32'h7FFF_FFFF, 1'b0);

        // Factors 0 and 1 are skipped, a repeated 4 is ignored, and the greedy
        // test rejects products such as 4 times 8.
        fac = '{8'd0, 8'd1, 8'd4, 8'd8, 8'd4, 8'd255};
        write_config(3'd6, fac, 1'b1);
        send_length(32'd32, 1'b0);
        send_length(32'd255, 1'b0);
        send_length(32'd257, 1'b0);

        fac = '{8'd255, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2};
        write_config(3'd1, fac, 1'b1);
        send_length(32'h7FFF_FFFF, 1'b0);
        send_length(32'd256, 1'b0);

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if ($urandom_range(0, 9) == 0)
                count = 3'd0;
            else
                count = 3'($urandom_range(1, 7));
            for (int k = 0; k < FACTOR_REGS; k++)
                fac[k] = pick_factor();
            write_config(count, fac, $urandom_range(0, 2) == 0);
            idling = (phase < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(0, 99) < 8)
                    send_length($urandom(), 1'b1);
                else
                    send_length(pick_length(), 1'b0);
            end
        end

        settle_block();
        if (check_errors == 0 && check_pending == 0)
            $display("tb_next_smooth_length: PASS");
        else
            $display("tb_next_smooth_length: FAIL");
        $finish;
    end

endmodule
